@@ hdl/icov_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icov_pkg
// Shared types and codes for the interval coverage tracker: sequencer
// states, entry relation codes, the step unit result and status codes.
// ----------------------------------------------------------------------------
package icov_pkg;

    localparam int OFFSET_W    = 64;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_COMMIT
    } t_state;

    typedef enum logic [1:0] {
        REL_BELOW,
        REL_ABOVE,
        REL_MERGE
    } t_rel;

    typedef struct packed {
        t_rel                rel;
        logic [OFFSET_W-1:0] merged_begin;
        logic [OFFSET_W-1:0] merged_end;
    } t_step;

endpackage

@@ hdl/interval_coverage_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_coverage_tracker
// Merges each incoming byte interval into a sorted table of disjoint
// intervals and reports status, total covered bytes and interval count.
//
//   channel | direction | handshake                 | beat payload
//   --------+-----------+---------------------------+-----------------------------
//   in      | input     | i_in_valid / o_in_stall   | i_start_offset, i_byte_length
//   out     | output    | o_out_valid / i_out_stall | o_status, o_covered_bytes,
//           |           |                           | o_interval_count
//
// An insert walks the stored intervals over the table read port, one entry a
// cycle through the shared compare unit; the walk pauses on an entry while the
// new interval is written ahead of it. Zero length and overflow skip the walk
// and go straight to commit.
// Synchronous reset empties the table at once; no clearing pass.
// The result register holds a beat under stall; the next item is taken
// meanwhile and its commit waits until the register is free.
// ----------------------------------------------------------------------------
module interval_coverage_tracker #(
    parameter int MAX_INTERVALS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [icov_pkg::OFFSET_W-1:0]        i_start_offset,
    input  logic [icov_pkg::OFFSET_W-1:0]        i_byte_length,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [icov_pkg::STATUS_W-1:0]        o_status,
    output logic [icov_pkg::OFFSET_W-1:0]        o_covered_bytes,
    output logic [icov_pkg::COUNT_OUT_W-1:0]     o_interval_count
);
    import icov_pkg::*;

    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

    t_state              r_state;
    t_state              n_state;
    logic                r_bank;
    logic [CW-1:0]       r_cnt;
    logic [OFFSET_W-1:0] r_total;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_n;
    logic                r_placed;
    logic                r_full;
    logic                r_upd;
    logic [OFFSET_W-1:0] r_nb;
    logic [OFFSET_W-1:0] r_ne;
    logic [OFFSET_W-1:0] r_sum_beg;
    logic [OFFSET_W-1:0] r_sum_end;
    logic [STATUS_W-1:0] r_status;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [OFFSET_W-1:0] r_out_cov;
    logic [COUNT_OUT_W-1:0] r_out_cnt;

    logic [OFFSET_W:0]   end_sum;
    logic                len_zero;
    logic                carry;
    logic                accept;
    logic                in_stall;
    logic                wr_req;
    logic                wr_en;
    logic                full_hit;
    logic [OFFSET_W-1:0] wr_b;
    logic [OFFSET_W-1:0] wr_e;
    logic                adv;
    logic                place;
    logic                do_merge;
    logic                commit_go;
    logic [CW-1:0]       rd_idx_next;
    logic [OFFSET_W-1:0] rd_begin;
    logic [OFFSET_W-1:0] rd_end;
    t_step               step;
    logic                commit_apply;
    logic [STATUS_W-1:0] commit_status;
    logic [OFFSET_W-1:0] commit_total;
    logic [CW-1:0]       commit_cnt;

    assign end_sum  = {1'b0, i_start_offset} + {1'b0, i_byte_length};
    assign len_zero = (i_byte_length == '0);
    assign carry    = end_sum[OFFSET_W];
    assign accept   = i_in_valid && !in_stall;

    icov_step u_step (
        .i_entry_begin (rd_begin),
        .i_entry_end   (rd_end),
        .i_cur_begin   (r_nb),
        .i_cur_end     (r_ne),
        .o_step        (step)
    );

    icov_table #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_bank  (~r_bank),
        .i_wr_idx   (r_n[IW-1:0]),
        .i_wr_begin (wr_b),
        .i_wr_end   (wr_e),
        .i_rd_bank  (r_bank),
        .i_rd_idx   (rd_idx_next[IW-1:0]),
        .o_rd_begin (rd_begin),
        .o_rd_end   (rd_end)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (len_zero || carry) ? S_COMMIT : S_WALK;
                end
            end
            S_WALK: begin
                if (r_idx == r_cnt) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (commit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_stall    = 1'b1;
        wr_req      = 1'b0;
        wr_b        = rd_begin;
        wr_e        = rd_end;
        adv         = 1'b0;
        place       = 1'b0;
        do_merge    = 1'b0;
        commit_go   = 1'b0;
        rd_idx_next = r_idx;
        case (r_state)
            S_IDLE: begin
                in_stall    = 1'b0;
                rd_idx_next = '0;
            end
            S_WALK: begin
                if (r_idx == r_cnt) begin
                    if (!r_placed) begin
                        wr_req = 1'b1;
                        wr_b   = r_nb;
                        wr_e   = r_ne;
                    end
                end else begin
                    case (step.rel)
                        REL_BELOW: begin
                            wr_req = 1'b1;
                            adv    = 1'b1;
                        end
                        REL_ABOVE: begin
                            wr_req = 1'b1;
                            if (!r_placed) begin
                                wr_b  = r_nb;
                                wr_e  = r_ne;
                                place = 1'b1;
                            end else begin
                                adv = 1'b1;
                            end
                        end
                        REL_MERGE: begin
                            do_merge = 1'b1;
                            adv      = 1'b1;
                        end
                        default: ;
                    endcase
                end
                if (adv) begin
                    rd_idx_next = CW'(r_idx + 1'b1);
                end
            end
            S_COMMIT: begin
                commit_go = !r_out_valid || !i_out_stall;
            end
            default: ;
        endcase
    end

    assign wr_en    = wr_req && (r_n != MAX_CNT);
    assign full_hit = wr_req && (r_n == MAX_CNT);

    assign commit_apply  = r_upd && !r_full;
    assign commit_status = r_full ? STAT_FULL : r_status;
    assign commit_total  = commit_apply ? (r_sum_end - r_sum_beg) : r_total;
    assign commit_cnt    = commit_apply ? r_n : r_cnt;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_cnt       <= '0;
            r_total     <= '0;
            r_idx       <= '0;
            r_n         <= '0;
            r_placed    <= 1'b0;
            r_full      <= 1'b0;
            r_upd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= ((r_state == S_COMMIT) && commit_go)
                           || (r_out_valid && i_out_stall);
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_idx    <= '0;
                        r_n      <= '0;
                        r_placed <= 1'b0;
                        r_full   <= 1'b0;
                        r_upd    <= !len_zero && !carry;
                    end
                end
                S_WALK: begin
                    if (adv) begin
                        r_idx <= CW'(r_idx + 1'b1);
                    end
                    if (place) begin
                        r_placed <= 1'b1;
                    end
                    if (wr_en) begin
                        r_n <= CW'(r_n + 1'b1);
                    end
                    if (full_hit) begin
                        r_full <= 1'b1;
                    end
                end
                S_COMMIT: begin
                    if (commit_go) begin
                        if (commit_apply) begin
                            r_bank  <= ~r_bank;
                            r_cnt   <= r_n;
                            r_total <= commit_total;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // working bounds, running sums and result beat
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_nb      <= i_start_offset;
                    r_ne      <= end_sum[OFFSET_W-1:0];
                    r_sum_beg <= '0;
                    r_sum_end <= '0;
                    r_status  <= (!len_zero && carry) ? STAT_OVERFLOW : STAT_OK;
                end
            end
            S_WALK: begin
                if (do_merge) begin
                    r_nb <= step.merged_begin;
                    r_ne <= step.merged_end;
                end
                if (wr_en) begin
                    r_sum_beg <= r_sum_beg + wr_b;
                    r_sum_end <= r_sum_end + wr_e;
                end
            end
            S_COMMIT: begin
                if (commit_go) begin
                    r_out_status <= commit_status;
                    r_out_cov    <= commit_total;
                    r_out_cnt    <= COUNT_OUT_W'(commit_cnt);
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall       = in_stall;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_covered_bytes  = r_out_cov;
    assign o_interval_count = r_out_cnt;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT)
        else $error("stored count beyond table size");

    a_walk_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx <= r_cnt) && r_upd)
        else $error("walk index past stored count");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_WALK) && (r_n < MAX_CNT))
        else $error("table write outside build bank");

    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && commit_go && commit_apply) |=> (r_bank != $past(r_bank)))
        else $error("committed table not switched in");

    a_err_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && commit_go && !commit_apply) |=> $stable(r_cnt) && $stable(r_bank))
        else $error("table changed on rejected item");

endmodule

@@ hdl/icov_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icov_step
// Shared compare unit: classifies one stored entry against the interval
// being merged and gives the joined bounds when the two overlap or touch.
// ----------------------------------------------------------------------------
module icov_step (
    input  logic [icov_pkg::OFFSET_W-1:0] i_entry_begin,
    input  logic [icov_pkg::OFFSET_W-1:0] i_entry_end,
    input  logic [icov_pkg::OFFSET_W-1:0] i_cur_begin,
    input  logic [icov_pkg::OFFSET_W-1:0] i_cur_end,
    output icov_pkg::t_step               o_step
);
    import icov_pkg::*;

    always_comb begin
        if (i_entry_end < i_cur_begin) begin
            o_step.rel = REL_BELOW;
        end else if (i_entry_begin > i_cur_end) begin
            o_step.rel = REL_ABOVE;
        end else begin
            o_step.rel = REL_MERGE;
        end
        o_step.merged_begin = (i_entry_begin < i_cur_begin) ? i_entry_begin : i_cur_begin;
        o_step.merged_end   = (i_entry_end > i_cur_end) ? i_entry_end : i_cur_end;
    end

endmodule

@@ hdl/icov_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icov_table
// Two-bank interval table. One bank holds the live table while the new
// table is built in the other; one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module icov_table #(
    parameter int MAX_INTERVALS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic                                  i_wr_bank,
    input  logic [((MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1)-1:0] i_wr_idx,
    input  logic [icov_pkg::OFFSET_W-1:0]         i_wr_begin,
    input  logic [icov_pkg::OFFSET_W-1:0]         i_wr_end,
    input  logic                                  i_rd_bank,
    input  logic [((MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1)-1:0] i_rd_idx,
    output logic [icov_pkg::OFFSET_W-1:0]         o_rd_begin,
    output logic [icov_pkg::OFFSET_W-1:0]         o_rd_end
);
    import icov_pkg::*;

    localparam int IW    = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int DEPTH = 2 * (2 ** IW);

    logic [OFFSET_W-1:0] r_mem_begin [DEPTH];
    logic [OFFSET_W-1:0] r_mem_end   [DEPTH];
    logic [OFFSET_W-1:0] r_rd_begin;
    logic [OFFSET_W-1:0] r_rd_end;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_begin[{i_wr_bank, i_wr_idx}] <= i_wr_begin;
            r_mem_end[{i_wr_bank, i_wr_idx}]   <= i_wr_end;
        end
        r_rd_begin <= r_mem_begin[{i_rd_bank, i_rd_idx}];
        r_rd_end   <= r_mem_end[{i_rd_bank, i_rd_idx}];
    end

    assign o_rd_begin = r_rd_begin;
    assign o_rd_end   = r_rd_end;

endmodule

@@ verif/interval_coverage_tracker_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_coverage_tracker_test
// Self-checking bench for the interval coverage tracker. A scoreboard keeps
// its own copy of the interval table, merges every accepted input beat into
// it and checks each output beat against the oldest expected report. A
// short directed run covers zero length, end overflow, touching and
// overlapping joins and a full table. Random intervals are then aimed at the
// stored entries, at the gaps between them and at fresh space, under three
// stall and gap profiles.
// ----------------------------------------------------------------------------
module interval_coverage_tracker_test;
    import icov_pkg::*;

    localparam int MAX_INTERVALS    = 16;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int QUIET_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 2 * MAX_INTERVALS + 8;

    typedef logic [OFFSET_W-1:0] t_offset;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        t_offset                covered;
        logic [COUNT_OUT_W-1:0] count;
    } t_coverage_report;

    class coverage_scoreboard #(int DEPTH = 16);
        t_offset          span_begin[DEPTH];
        t_offset          span_end[DEPTH];
        int unsigned      span_count;
        t_offset          covered;
        t_coverage_report expected_q[$];
        int unsigned      mismatches;

        function new();
            span_count = 0;
            covered    = '0;
            mismatches = 0;
        endfunction

        function void note_interval(t_offset start_off, t_offset len);
            t_offset          nb;
            t_offset          ne;
            t_offset          sum;
            t_offset          wb[DEPTH+1];
            t_offset          we[DEPTH+1];
            int unsigned      n;
            bit               placed;
            t_coverage_report rep;
            rep.status = STAT_OK;
            nb         = start_off;
            ne         = '0;
            n          = 0;
            placed     = 1'b0;
            sum        = '0;
            if (len == '0) begin
                rep.status = STAT_OK;
            end else if (start_off > ~len) begin
                rep.status = STAT_OVERFLOW;
            end else begin
                ne = start_off + len;
                for (int i = 0; i < span_count; i++) begin
                    if (span_end[i] < nb) begin
                        wb[n] = span_begin[i];
                        we[n] = span_end[i];
                        n++;
                    end else if (span_begin[i] > ne) begin
                        if (!placed) begin
                            wb[n]  = nb;
                            we[n]  = ne;
                            n++;
                            placed = 1'b1;
                        end
                        wb[n] = span_begin[i];
                        we[n] = span_end[i];
                        n++;
                    end else begin
                        if (span_begin[i] < nb) nb = span_begin[i];
                        if (span_end[i] > ne) ne = span_end[i];
                    end
                end
                if (!placed) begin
                    wb[n] = nb;
                    we[n] = ne;
                    n++;
                end
                if (n > DEPTH) begin
                    rep.status = STAT_FULL;
                end else begin
                    for (int i = 0; i < n; i++) begin
                        span_begin[i] = wb[i];
                        span_end[i]   = we[i];
                        sum += we[i] - wb[i];
                    end
                    span_count = n;
                    covered    = sum;
                end
            end
            rep.covered = covered;
            rep.count   = span_count[COUNT_OUT_W-1:0];
            expected_q  = {expected_q, rep};
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, t_offset cov,
                                   logic [COUNT_OUT_W-1:0] count);
            t_coverage_report exp;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected", $time);
                return;
            end
            exp = expected_q.pop_front();
            if (exp.status != status || exp.covered != cov || exp.count != count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch status %0d/%0d covered %0h/%0h count %0d/%0d",
                             $time, exp.status, status, exp.covered, cov, exp.count, count);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_offset                i_start_offset;
    t_offset                i_byte_length;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [STATUS_W-1:0]    o_status;
    t_offset                o_covered_bytes;
    logic [COUNT_OUT_W-1:0] o_interval_count;

    coverage_scoreboard #(MAX_INTERVALS) sb;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned quiet_cycles;

    interval_coverage_tracker #(
        .MAX_INTERVALS(MAX_INTERVALS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_start_offset  (i_start_offset),
        .i_byte_length   (i_byte_length),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_covered_bytes (o_covered_bytes),
        .o_interval_count(o_interval_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_covered_bytes, o_interval_count);
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic t_offset rand_offset();
        return {$urandom, $urandom};
    endfunction

    task automatic send_interval(t_offset start_off, t_offset len);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_start_offset = start_off;
        i_byte_length  = len;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_interval(start_off, len);
    endtask

    task automatic send_random_interval();
        int unsigned kind;
        int unsigned cnt;
        int unsigned i;
        int unsigned j;
        int unsigned top;
        t_offset     s;
        t_offset     l;
        kind = $urandom_range(0, 99);
        cnt  = sb.span_count;
        if (kind >= 45 && kind < 75 && cnt == 0) kind = 20;
        if (kind >= 75 && kind < 95 && cnt < 2) kind = 20;
        i = (cnt > 0) ? $urandom_range(0, cnt - 1) : 0;
        if (kind < 5) begin
            s = rand_offset();
            l = '0;
        end else if (kind < 11) begin
            // end lands just past the top of the offset range
            l = rand_offset() | t_offset'(1);
            s = ~l + t_offset'($urandom_range(1, 16));
        end else if (kind < 45) begin
            s = rand_offset();
            l = t_offset'($urandom_range(1, 4096));
        end else if (kind < 60) begin
            s = sb.span_begin[i] + rand_offset() % (sb.span_end[i] - sb.span_begin[i]);
            l = t_offset'($urandom_range(1, 8192));
        end else if (kind < 75) begin
            l = t_offset'($urandom_range(1, 512));
            if ($urandom_range(0, 1) == 0) begin
                s = sb.span_end[i];
            end else begin
                if (sb.span_begin[i] < l) l = sb.span_begin[i];
                if (l == '0) begin
                    s = sb.span_end[i];
                    l = t_offset'(1);
                end else begin
                    s = sb.span_begin[i] - l;
                end
            end
        end else if (kind < 95) begin
            // fill the gap between neighbors, joining them
            i   = $urandom_range(0, cnt - 2);
            top = (i + 2 < cnt - 1) ? i + 2 : cnt - 1;
            j   = $urandom_range(i + 1, top);
            s   = sb.span_end[i];
            l   = sb.span_begin[j] - s + t_offset'($urandom_range(0, 2));
        end else begin
            s = rand_offset() | {1'b1, {(OFFSET_W-1){1'b0}}};
            l = (rand_offset() & ~s) >> $urandom_range(0, 40);
        end
        send_interval(s, l);
    endtask

    initial begin
        sb             = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_start_offset = '0;
        i_byte_length  = '0;
        send_idle_pct  = 19;
        recv_idle_pct  = 72;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table, range edges
        send_interval('0, '0);
        send_interval('1, t_offset'(1));
        send_interval(t_offset'(1), '1);
        send_interval({1'b1, {(OFFSET_W-1){1'b0}}}, {1'b1, {(OFFSET_W-1){1'b0}}});
        send_interval('1 - t_offset'(1), t_offset'(1));
        send_interval('0, t_offset'(1));
        // joins by touch, overlap, containment
        send_interval(t_offset'(100), t_offset'(100));
        send_interval(t_offset'(300), t_offset'(100));
        send_interval(t_offset'(200), t_offset'(100));
        send_interval(t_offset'(98), t_offset'(2));
        send_interval(t_offset'(50), t_offset'(49));
        send_interval(t_offset'(120), t_offset'(10));
        send_interval(t_offset'(40), t_offset'(460));
        // fill the table, then push past it
        for (int k = 1; k <= 13; k++)
            send_interval(t_offset'(1000 * k), t_offset'(10));
        send_interval(t_offset'(20000), t_offset'(10));
        send_interval('1, t_offset'(2));
        send_interval('1, '0);
        send_interval(t_offset'(13010), t_offset'(10));

        for (int p = 0; p < 3; p++) begin
            if (p == 1) begin
                send_idle_pct = 72;
                recv_idle_pct = 19;
            end else if (p == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_random_interval();
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
